FILE: hdl/rgbab_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbab_pkg
// shared constants and pixel helpers for the rgb565 alpha blend block
// ============================================================================
package rgbab_pkg;

    // item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    // blend modes, code 3 acts as passthrough
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_COLOR = 2'd1;
    localparam logic [1:0] MODE_COVER = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
    localparam logic [1:0] REG_BLEND_COLOR = 2'd1;
    localparam logic [1:0] REG_ALPHA_PCT   = 2'd2;
    localparam logic [1:0] REG_COVER_NARROW = 2'd3;

    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 8;
    localparam int PIXEL_W     = 16;
    localparam int WEIGHT_W    = 6;
    localparam int PCT_W       = 7;

    // floor(pct*16/25) == (pct*1311) >> 11 for every pct below 100
    localparam logic [17:0] WEIGHT_RECIP = 18'd1311;
    localparam logic [PCT_W-1:0] PCT_SAT = 7'd100;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 6'd63;

    // percent to 6-bit weight, saturating at 63
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [PCT_W-1:0] pct);
        logic [17:0] prod;
        prod = 18'(pct) * WEIGHT_RECIP;
        if (pct >= PCT_SAT)
            return WEIGHT_MAX;
        return prod[16:11];
    endfunction

    // rgb565 to rgb332 by truncation
    function automatic logic [7:0] to_narrow(input logic [PIXEL_W-1:0] p);
        return {p[15:13], p[10:8], p[4:3]};
    endfunction

    // rgb332 back to rgb565, low bits zero
    function automatic logic [PIXEL_W-1:0] narrow_to_565(input logic [7:0] v);
        return {v[7:5], 2'b00, v[4:2], 3'b000, v[1:0], 3'b000};
    endfunction

    // per channel (p*a + c*(63-a)) >> 6
    function automatic logic [PIXEL_W-1:0] mix565(
        input logic [PIXEL_W-1:0]  p,
        input logic [PIXEL_W-1:0]  c,
        input logic [WEIGHT_W-1:0] a
    );
        logic [WEIGHT_W-1:0] na;
        logic [11:0] r;
        logic [11:0] g;
        logic [11:0] b;
        na = WEIGHT_MAX - a;
        r = 12'(p[15:11]) * 12'(a) + 12'(c[15:11]) * 12'(na);
        g = 12'(p[10:5])  * 12'(a) + 12'(c[10:5])  * 12'(na);
        b = 12'(p[4:0])   * 12'(a) + 12'(c[4:0])   * 12'(na);
        return {r[10:6], g[11:6], b[10:6]};
    endfunction

endpackage

FILE: hdl/rgbab_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbab_ram
// generic single port ram, one write and one registered read per cycle, sharing one address
// ============================================================================
module rgbab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 57600
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/rgbab_mix.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbab_mix
// blend datapath: picks the background and mixes it with the item pixel
// ============================================================================
module rgbab_mix (
    input  logic [rgbab_pkg::PIXEL_W-1:0]  pixel,
    input  logic [rgbab_pkg::PIXEL_W-1:0]  cover_word,
    input  logic                           cover_hit,
    input  logic [1:0]                     mode,
    input  logic [rgbab_pkg::PIXEL_W-1:0]  color,
    input  logic [rgbab_pkg::WEIGHT_W-1:0] weight,
    input  logic                           narrow,
    output logic [rgbab_pkg::PIXEL_W-1:0]  result
);
    import rgbab_pkg::*;

    logic [PIXEL_W-1:0] cover_raw;
    logic [PIXEL_W-1:0] cover_565;

    // outside the image the cover reads as zero
    assign cover_raw = cover_hit ? cover_word : '0;
    assign cover_565 = narrow ? narrow_to_565(cover_raw[7:0]) : cover_raw;

    always_comb
    begin
        case (mode)
            MODE_COLOR: result = mix565(pixel, color, weight);
            MODE_COVER: result = mix565(pixel, cover_565, weight);
            default:    result = pixel;
        endcase
    end

endmodule

FILE: hdl/rgb565_alpha_blend_with_cover.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb565_alpha_blend_with_cover
// rgb565 pixel blender with a cover image store
// ============================================================================
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------
//  input     | in_valid / in_ready  | kind, pixel_x, pixel_y, pixel_in
//  output    | out_valid / out_ready| out_x, out_y, pixel_out
//  config    | cfg_we               | cfg_index, cfg_data
//
//  one item per cycle unless a held result stalls the input; a draw item
//  passes through the input reg, the cover ram read stage and the result reg
//  store items write the cover ram from the input reg and give no result
//  the ram has one port, shared by stores and reads since only one item
//  sits in the input reg at a time
//  each stage moves on when the one after it is empty or emptying, so a
//  held result only stalls the input once the whole pipe is full
//  reset clears valids and config; cover contents are not cleared
//
module rgb565_alpha_blend_with_cover #(
    parameter int IMAGE_WIDTH  = 240,
    parameter int IMAGE_HEIGHT = 240
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [rgbab_pkg::COORD_W-1:0]    pixel_x,
    input  logic [rgbab_pkg::COORD_W-1:0]    pixel_y,
    input  logic [rgbab_pkg::PIXEL_W-1:0]    pixel_in,
    // result items
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rgbab_pkg::COORD_W-1:0]    out_x,
    output logic [rgbab_pkg::COORD_W-1:0]    out_y,
    output logic [rgbab_pkg::PIXEL_W-1:0]    pixel_out
);
    import rgbab_pkg::*;

    localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // config registers; alpha is kept as its 6-bit weight
    logic [1:0]          mode_reg;
    logic [PIXEL_W-1:0]  color_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                narrow_reg;

    // input stage
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [COORD_W-1:0]  s1_x_reg;
    logic [COORD_W-1:0]  s1_y_reg;
    logic [PIXEL_W-1:0]  s1_pix_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_inside_reg;

    // ram read stage
    logic                s2_valid_reg;
    logic [COORD_W-1:0]  s2_x_reg;
    logic [COORD_W-1:0]  s2_y_reg;
    logic [PIXEL_W-1:0]  s2_pix_reg;
    logic                s2_inside_reg;

    // result register
    logic                out_valid_reg;
    logic [COORD_W-1:0]  out_x_reg;
    logic [COORD_W-1:0]  out_y_reg;
    logic [PIXEL_W-1:0]  out_pix_reg;

    logic                in_fire;
    logic                inside_c;
    logic [ADDR_W-1:0]   addr_c;
    logic                out_free;
    logic                s2_free;
    logic                s1_is_store;
    logic                s1_leave;
    logic                s2_load;
    logic                ram_we;
    logic [PIXEL_W-1:0]  ram_wdata;
    logic [PIXEL_W-1:0]  ram_rdata;
    logic [PIXEL_W-1:0]  mix_result;

    // ------------------------------------------------------------------
    // handshake and stage flow
    // ------------------------------------------------------------------
    assign out_free    = !out_valid_reg || out_ready;
    assign s2_free     = !s2_valid_reg || out_free;
    assign s1_is_store = (s1_kind_reg == KIND_STORE);
    // a store retires from the input reg straight into the ram
    assign s1_leave    = s1_valid_reg && (s1_is_store || s2_free);
    assign s2_load     = s1_valid_reg && !s1_is_store && s2_free;
    assign in_ready    = !s1_valid_reg || s1_leave;
    assign in_fire     = in_valid && in_ready;

    // row-major cover address, only meaningful inside the image
    assign inside_c = (32'(pixel_x) < IMAGE_WIDTH) && (32'(pixel_y) < IMAGE_HEIGHT);
    assign addr_c   = ADDR_W'(32'(pixel_y) * IMAGE_WIDTH + 32'(pixel_x));

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PASS;
            color_reg  <= '0;
            weight_reg <= '0;
            narrow_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:   mode_reg   <= cfg_data[1:0];
                REG_BLEND_COLOR:  color_reg  <= cfg_data;
                REG_ALPHA_PCT:    weight_reg <= weight_of(cfg_data[PCT_W-1:0]);
                REG_COVER_NARROW: narrow_reg <= cfg_data[0];
                default:          mode_reg   <= mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s2_load;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg   <= kind;
            s1_x_reg      <= pixel_x;
            s1_y_reg      <= pixel_y;
            s1_pix_reg    <= pixel_in;
            s1_addr_reg   <= addr_c;
            s1_inside_reg <= inside_c;
        end
        if (s2_load)
        begin
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_pix_reg    <= s1_pix_reg;
            s2_inside_reg <= s1_inside_reg;
        end
        if (out_free && s2_valid_reg)
        begin
            out_x_reg   <= s2_x_reg;
            out_y_reg   <= s2_y_reg;
            out_pix_reg <= mix_result;
        end
    end

    // ------------------------------------------------------------------
    // cover image store
    // ------------------------------------------------------------------
    // stores outside the image are dropped
    assign ram_we    = s1_valid_reg && s1_is_store && s1_inside_reg;
    assign ram_wdata = narrow_reg ? {8'd0, to_narrow(s1_pix_reg)} : s1_pix_reg;

    rgbab_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_cover_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (s2_load),
        .addr  (s1_addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // blend
    // ------------------------------------------------------------------
    rgbab_mix u_mix (
        .pixel      (s2_pix_reg),
        .cover_word (ram_rdata),
        .cover_hit  (s2_inside_reg),
        .mode       (mode_reg),
        .color      (color_reg),
        .weight     (weight_reg),
        .narrow     (narrow_reg),
        .result     (mix_result)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign pixel_out = out_pix_reg;

endmodule

FILE: hdl/rgbab_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbab_checker
// port level checks on the blend block, bound to the top level
// ============================================================================
module rgbab_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_we,
    input logic [1:0]                       cfg_index,
    input logic [rgbab_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             kind,
    input logic [rgbab_pkg::COORD_W-1:0]    pixel_x,
    input logic [rgbab_pkg::COORD_W-1:0]    pixel_y,
    input logic [rgbab_pkg::PIXEL_W-1:0]    pixel_in,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [rgbab_pkg::COORD_W-1:0]    out_x,
    input logic [rgbab_pkg::COORD_W-1:0]    out_y,
    input logic [rgbab_pkg::PIXEL_W-1:0]    pixel_out
);
    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(pixel_out))
        else $error("result changed while stalled");

    // with the output empty the pipe cannot be full
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // draining with out_ready high and no new item taken leaves nothing behind
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
            && !$past(in_fire, 1) && !$past(in_fire, 2) && !$past(in_fire, 3)
            |-> !out_valid)
        else $error("result appeared with no item in flight");

    // reset leaves no result behind
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind rgb565_alpha_blend_with_cover rgbab_checker u_rgbab_checker (.*);
